/* hdl/assert_macros.svh */
// Assertion macros shared by the life grid engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LGGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/lgge_pkg.sv */
// Shared constants and the B3/S23 rule function for the life grid engine.
package lgge_pkg;

    // Operation codes; code 3 is unused and leaves the grid unchanged.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register indexes on the config port.
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Width for comparing sizes, indexes and register values (grid up to 256).
    localparam int CMP_W = 9;

    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    function automatic logic life_rule(input logic alive, input logic [7:0] nbrs);
        logic [3:0] cnt;
        cnt = 4'($countones(nbrs));
        if (alive) begin
            return (cnt == SURVIVE_MIN) || (cnt == BIRTH_COUNT);
        end
        return cnt == BIRTH_COUNT;
    endfunction

endpackage

/* hdl/lgge_in_if.sv */
// Command channel: operation word into the life grid engine.
interface lgge_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_value;
    logic [7:0] generation_count;

    modport source (
        output valid, operation, cell_row, cell_col, cell_value, generation_count,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_row, cell_col, cell_value, generation_count,
        output ready
    );
endinterface

/* hdl/lgge_out_if.sv */
// Result channel: one word per command out of the life grid engine.
interface lgge_out_if;
    logic valid;
    logic ready;
    logic cell_live;
    logic out_of_range;

    modport source (
        output valid, cell_live, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, cell_live, out_of_range,
        output ready
    );
endinterface

/* hdl/lgge_row_cell.sv */
// One row of the grid: a link in the circular row chain.
module lgge_row_cell #(
    parameter int MAX_COLS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [MAX_COLS-1:0] i_data,
    output logic [MAX_COLS-1:0] o_data
);

    logic [MAX_COLS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

/* hdl/lgge_row_rule.sv */
// Next-generation value of one whole row from the row itself and its two neighbor rows.
module lgge_row_rule #(
    parameter int MAX_COLS = 64
) (
    input  logic [MAX_COLS-1:0] i_above,
    input  logic [MAX_COLS-1:0] i_cur,
    input  logic [MAX_COLS-1:0] i_below,
    input  logic [MAX_COLS-1:0] i_col_mask,
    input  logic                i_row_active,
    output logic [MAX_COLS-1:0] o_next
);

    // Zero pad on both sides so edge columns see dead neighbors.
    logic [MAX_COLS+1:0] w_a;
    logic [MAX_COLS+1:0] w_m;
    logic [MAX_COLS+1:0] w_b;

    assign w_a = {1'b0, i_above & i_col_mask, 1'b0};
    assign w_m = {1'b0, i_cur   & i_col_mask, 1'b0};
    assign w_b = {1'b0, i_below & i_col_mask, 1'b0};

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        logic [7:0] w_nbrs;
        assign w_nbrs = {w_a[c+2:c], w_m[c+2], w_m[c], w_b[c+2:c]};
        assign o_next[c] = (i_row_active && i_col_mask[c])
                         ? lgge_pkg::life_rule(i_cur[c], w_nbrs) : i_cur[c];
    end

endmodule

/* hdl/life_grid_generation_engine.sv */
// B3/S23 life grid engine. The grid lives in a circular chain of MAX_ROWS row
// cells; a cell write or read rotates the chain once, a run rotates it once
// per generation, one row per cycle, while the row at the head is read,
// patched or replaced by its next generation (computed from the saved row
// above and the row behind it). Out-of-range, zero-generation and unused
// commands do not rotate the chain and go straight to the result. A command
// is taken whenever the engine is idle, even while the previous result still
// waits on the result channel.
// grid_rows and grid_cols sit at byte addresses 0 and 4 and reset to 64.
module life_grid_generation_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lgge_in_if.sink          i_cmd,
    lgge_out_if.source       o_res,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CMP_W = lgge_pkg::CMP_W;
    localparam int SW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam logic [CMP_W-1:0] MAX_R     = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] MAX_C     = CMP_W'(MAX_COLS);
    localparam logic [SW-1:0]    LAST_STEP = SW'(MAX_ROWS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RESULT
    } t_state;

    t_state r_state, n_state;

    logic [lgge_pkg::CFG_W-1:0] r_grid_rows, r_grid_cols;

    logic [1:0]          r_op, n_op;
    logic [5:0]          r_row, n_row;
    logic [5:0]          r_col, n_col;
    logic                r_val, n_val;
    logic [7:0]          r_gens, n_gens;
    logic [SW-1:0]       r_step, n_step;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic                r_res_live, n_res_live;
    logic                r_res_oor, n_res_oor;
    logic                r_out_valid, n_out_valid;
    logic                r_out_live, n_out_live;
    logic                r_out_oor, n_out_oor;

    logic [MAX_COLS-1:0] w_row [MAX_ROWS];
    logic [MAX_COLS-1:0] w_tail;
    logic [MAX_COLS-1:0] w_gen_row;
    logic [MAX_COLS-1:0] w_above;
    logic [MAX_COLS-1:0] w_below;
    logic [MAX_COLS-1:0] w_col_mask;
    logic                w_shift;
    logic [CMP_W-1:0]    w_nr, w_nc;
    logic [CMP_W-1:0]    w_step_ext;
    logic [CMP_W-1:0]    w_col_ext;
    logic [CW-1:0]       w_col_idx;
    logic                w_row_active;
    logic                w_at_target;
    logic                w_in_oor;
    logic                w_cmd_fire;
    logic                w_cfg_wr;
    logic                w_res_load;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == lgge_pkg::REG_GRID_COLS)
                    ? 32'(r_grid_cols) : 32'(r_grid_rows);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lgge_pkg::CFG_RESET;
            r_grid_cols <= lgge_pkg::CFG_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == lgge_pkg::REG_GRID_ROWS) begin
                r_grid_rows <= pwdata[lgge_pkg::CFG_W-1:0];
            end else begin
                r_grid_cols <= pwdata[lgge_pkg::CFG_W-1:0];
            end
        end
    end

    // sizes in use, clipped to the physical grid
    assign w_nr = (CMP_W'(r_grid_rows) > MAX_R) ? MAX_R : CMP_W'(r_grid_rows);
    assign w_nc = (CMP_W'(r_grid_cols) > MAX_C) ? MAX_C : CMP_W'(r_grid_cols);

    for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
        assign w_col_mask[c] = CMP_W'(c) < w_nc;
    end

    // ---------------- row chain ----------------
    assign w_shift = (r_state == S_SWEEP);

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_rows
        logic [MAX_COLS-1:0] w_in;
        if (i == MAX_ROWS - 1) begin : g_last
            assign w_in = w_tail;
        end else begin : g_mid
            assign w_in = w_row[i+1];
        end
        lgge_row_cell #(
            .MAX_COLS (MAX_COLS)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_data  (w_in),
            .o_data  (w_row[i])
        );
    end

    assign w_step_ext   = CMP_W'(r_step);
    assign w_row_active = w_step_ext < w_nr;
    assign w_at_target  = w_step_ext == CMP_W'(r_row);
    assign w_col_ext    = CMP_W'(r_col);
    assign w_col_idx    = w_col_ext[CW-1:0];

    // row above is dead for the top row, row below is dead past the last row in use
    assign w_above = (r_step == '0) ? '0 : r_prev;
    assign w_below = ((w_step_ext + CMP_W'(1)) < w_nr) ? w_row[1] : '0;

    lgge_row_rule #(
        .MAX_COLS (MAX_COLS)
    ) u_rule (
        .i_above      (w_above),
        .i_cur        (w_row[0]),
        .i_below      (w_below),
        .i_col_mask   (w_col_mask),
        .i_row_active (w_row_active),
        .o_next       (w_gen_row)
    );

    always_comb begin
        w_tail = w_row[0];
        case (r_op)
            lgge_pkg::OP_RUN: begin
                w_tail = w_gen_row;
            end
            lgge_pkg::OP_WRITE: begin
                if (w_at_target) begin
                    w_tail[w_col_idx] = r_val;
                end
            end
            default: begin
                w_tail = w_row[0];
            end
        endcase
    end

    // ---------------- control ----------------
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign w_in_oor    = (CMP_W'(i_cmd.cell_row) >= w_nr) ||
                         (CMP_W'(i_cmd.cell_col) >= w_nc);
    assign w_res_load  = (r_state == S_RESULT) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_gens      = r_gens;
        n_step      = r_step;
        n_prev      = r_prev;
        n_res_live  = r_res_live;
        n_res_oor   = r_res_oor;
        n_out_valid = r_out_valid;
        n_out_live  = r_out_live;
        n_out_oor   = r_out_oor;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_cmd_fire) begin
                    n_op       = i_cmd.operation;
                    n_row      = i_cmd.cell_row;
                    n_col      = i_cmd.cell_col;
                    n_val      = i_cmd.cell_value;
                    n_gens     = i_cmd.generation_count;
                    n_step     = '0;
                    n_res_live = 1'b0;
                    n_res_oor  = 1'b0;
                    n_state    = S_RESULT;
                    case (i_cmd.operation)
                        lgge_pkg::OP_WRITE, lgge_pkg::OP_READ: begin
                            if (w_in_oor) begin
                                n_res_oor = 1'b1;
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        lgge_pkg::OP_RUN: begin
                            if (i_cmd.generation_count != '0) begin
                                n_state = S_SWEEP;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                n_prev = w_row[0];
                n_step = r_step + SW'(1);
                if (r_op == lgge_pkg::OP_READ && w_at_target) begin
                    n_res_live = w_row[0][w_col_idx];
                end
                if (r_step == LAST_STEP) begin
                    n_step = '0;
                    if (r_op == lgge_pkg::OP_RUN && r_gens > 8'd1) begin
                        n_gens = r_gens - 8'd1;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_live  = r_res_live;
                    n_out_oor   = r_res_oor;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_gens      <= '0;
            r_op        <= lgge_pkg::OP_READ;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_gens      <= n_gens;
            r_op        <= n_op;
        end
        r_row      <= n_row;
        r_col      <= n_col;
        r_val      <= n_val;
        r_prev     <= n_prev;
        r_res_live <= n_res_live;
        r_res_oor  <= n_res_oor;
        r_out_live <= n_out_live;
        r_out_oor  <= n_out_oor;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.cell_live    = r_out_live;
    assign o_res.out_of_range = r_out_oor;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `LGGE_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, w_cmd_fire, !i_cmd.ready)
    `LGGE_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_res_load, r_out_valid && (r_state == S_IDLE))
    `LGGE_ASSERT_SAME(a_live_excl_oor, i_clk, i_rst_n, r_out_valid, !(r_out_live && r_out_oor))

endmodule
